[rtl/fpt_pkg.sv]
package fpt_pkg;

  localparam int FAN_W       = 3;
  localparam int PCT_W       = 7;
  localparam int TACH_W      = 20;
  localparam int PERIOD_W    = TACH_W + 1;
  localparam int RPM_W       = 25;
  localparam int DUTY_W      = 8;
  localparam int WDOG_W      = 20;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 1;
  localparam int NUM_FANS    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RPM_W-1:0]  RPM_NUM          = 25'd30000000;
  localparam logic [WDOG_W-1:0] ELAPSED_MAX      = 20'hFFFFF;
  localparam logic [WDOG_W-1:0] WDOG_PERIOD_INIT = 20'd30000;
  localparam logic [PCT_W-1:0]  EMERG_PCT_INIT   = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_MAX         = 8'd255;
  // 2^22 / 100 rounded up, exact floor for products up to 127 * 255
  localparam logic [30:0]       RECIP_100        = 31'd41944;

  localparam logic [CFG_IDX_W-1:0] CFG_WDOG_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERG_PCT   = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_KICK,
    OP_SET,
    OP_GET
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BAD_FAN,
    STAT_WDOG
  } status_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_KICK,
    CMD_SET,
    CMD_GET,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [FAN_W-1:0]    fan_number;
    logic [PCT_W-1:0]    percent;
    logic [TACH_W-1:0]   tach_high_us;
    logic [TACH_W-1:0]   tach_low_us;
  } in_word_t;

  typedef struct packed {
    status_t             status;
    logic [RPM_W-1:0]    rpm;
    logic [DUTY_W-1:0]   duty_fan_one;
    logic [DUTY_W-1:0]   duty_fan_two;
    logic [DUTY_W-1:0]   duty_fan_three;
    logic [DUTY_W-1:0]   duty_fan_four;
  } out_word_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [FAN_W-1:0]    fan_number;
    logic [PERIOD_W-1:0] period;
    logic [DUTY_W-1:0]   duty;
  } cmd_t;

  // floor(pct * 255 / 100), saturated at 255
  function automatic logic [DUTY_W-1:0] duty_from_percent(input logic [PCT_W-1:0] pct);
    logic [14:0] scaled;
    logic [30:0] prod;
    logic [8:0]  q;
    scaled = (15'(pct) << 8) - 15'(pct);
    prod   = 31'(scaled) * RECIP_100;
    q      = prod[30:22];
    return (q > 9'(DUTY_MAX)) ? DUTY_MAX : q[DUTY_W-1:0];
  endfunction

endpackage

[rtl/fan_pwm_tach_watchdog_controller.sv]
// multi-fan pwm controller with a millisecond watchdog failsafe
// input channel: in_valid / in_ready carrying in_word (opcode, fan number,
//   percent, tach high and low times); each accepted word gives one result
// output channel: out_valid / out_ready carrying out_word (status, rpm and
//   the duties of fans one to four after the command)
// configuration: cfg_we with cfg_index and cfg_data, write only while idle;
//   index 0 watchdog period in ms, index 1 emergency percent
// path: tick, kick, set, invalid and zero-period get commands go from accept
//   through a queue slot to the registered out_word; a get with a nonzero
//   period holds the back end on the divider, one of 25 quotient bits a cycle
// throughput: one command per cycle for all but get, while results are taken
// a small command queue sits between the decoder and the executing back end,
//   so input words keep being taken while a result waits on the output
// reset: duties go to 255, watchdog count to zero, period 30000 ms and
//   emergency percent 100; queue and output register are emptied
// a stalled receiver holds out_word; the queue then fills and in_ready drops
module fan_pwm_tach_watchdog_controller #(
  parameter int NUM_FANS    = fpt_pkg::NUM_FANS,
  parameter int QUEUE_DEPTH = fpt_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fpt_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fpt_pkg::out_word_t             out_word,
  input  logic                           cfg_we,
  input  logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpt_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [fpt_pkg::WDOG_W-1:0] wdog_period;
  logic [fpt_pkg::PCT_W-1:0]  emerg_pct;
  logic                       push;
  logic                       full;
  logic                       pop;
  logic                       empty;
  fpt_pkg::cmd_t              push_cmd;
  fpt_pkg::cmd_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      wdog_period <= fpt_pkg::WDOG_PERIOD_INIT;
      emerg_pct   <= fpt_pkg::EMERG_PCT_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        fpt_pkg::CFG_WDOG_PERIOD: wdog_period <= cfg_data[fpt_pkg::WDOG_W-1:0];
        fpt_pkg::CFG_EMERG_PCT:   emerg_pct   <= cfg_data[fpt_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  fpt_front #(
    .NUM_FANS (NUM_FANS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  fpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  fpt_back #(
    .NUM_FANS (NUM_FANS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wdog_period (wdog_period),
    .emerg_pct   (emerg_pct),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule

[rtl/fpt_front.sv]
module fpt_front #(
  parameter int NUM_FANS = fpt_pkg::NUM_FANS
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  fpt_pkg::in_word_t in_word,
  output logic              push,
  output fpt_pkg::cmd_t     push_cmd,
  input  logic              full
);

  logic fan_ok;

  assign in_ready = !full;
  assign push     = in_valid && !full;
  assign fan_ok   = (in_word.fan_number != '0) &&
                    (in_word.fan_number <= fpt_pkg::FAN_W'(NUM_FANS));

  always_comb begin
    push_cmd.fan_number = in_word.fan_number;
    push_cmd.period     = fpt_pkg::PERIOD_W'(in_word.tach_high_us) +
                          fpt_pkg::PERIOD_W'(in_word.tach_low_us);
    push_cmd.duty       = fpt_pkg::duty_from_percent(in_word.percent);
    case (in_word.opcode)
      fpt_pkg::OP_TICK: push_cmd.kind = fpt_pkg::CMD_TICK;
      fpt_pkg::OP_KICK: push_cmd.kind = fpt_pkg::CMD_KICK;
      fpt_pkg::OP_SET:  push_cmd.kind = fan_ok ? fpt_pkg::CMD_SET : fpt_pkg::CMD_BAD;
      fpt_pkg::OP_GET:  push_cmd.kind = fan_ok ? fpt_pkg::CMD_GET : fpt_pkg::CMD_BAD;
      default:          push_cmd.kind = fpt_pkg::CMD_BAD;
    endcase
  end

endmodule

[rtl/fpt_queue.sv]
module fpt_queue #(
  parameter int DEPTH = fpt_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fpt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output fpt_pkg::cmd_t head,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fpt_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/fpt_div.sv]
module fpt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fpt_pkg::PERIOD_W-1:0] divisor,
  output logic                         busy,
  output logic [fpt_pkg::RPM_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(fpt_pkg::RPM_W);

  logic [fpt_pkg::PERIOD_W-1:0] dvs;
  logic [fpt_pkg::PERIOD_W-1:0] rem;
  logic [fpt_pkg::PERIOD_W:0]   trial;
  logic [fpt_pkg::PERIOD_W:0]   diff;
  logic [CNT_W-1:0]             cnt;
  logic                         fits;

  // restoring division of the constant numerator, one quotient bit a cycle
  always_comb begin
    trial = {rem, fpt_pkg::RPM_NUM[cnt]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      cnt <= CNT_W'(fpt_pkg::RPM_W - 1);
    end else if (busy) begin
      rem      <= fits ? diff[fpt_pkg::PERIOD_W-1:0] : trial[fpt_pkg::PERIOD_W-1:0];
      quotient <= {quotient[fpt_pkg::RPM_W-2:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

[rtl/fpt_back.sv]
module fpt_back #(
  parameter int NUM_FANS = fpt_pkg::NUM_FANS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fpt_pkg::WDOG_W-1:0]   wdog_period,
  input  logic [fpt_pkg::PCT_W-1:0]    emerg_pct,
  input  fpt_pkg::cmd_t                head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fpt_pkg::out_word_t           out_word
);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [fpt_pkg::WDOG_W-1:0]    elapsed;
  logic [fpt_pkg::WDOG_W-1:0]    elapsed_next;
  logic [fpt_pkg::WDOG_W-1:0]    elapsed_inc;
  logic [fpt_pkg::DUTY_W-1:0]    duty [NUM_FANS];
  logic [fpt_pkg::DUTY_W-1:0]    duty_next [NUM_FANS];
  logic [fpt_pkg::DUTY_W-1:0]    shown [4];
  logic [fpt_pkg::DUTY_W-1:0]    emerg_duty;
  logic                          wd_fire;
  logic                          out_free;
  logic                          load;
  fpt_pkg::status_t              res_status;
  logic [fpt_pkg::RPM_W-1:0]     res_rpm;
  logic                          div_start;
  logic                          div_busy;
  logic [fpt_pkg::RPM_W-1:0]     div_quotient;

  fpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (head.period),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  assign emerg_duty  = fpt_pkg::duty_from_percent(emerg_pct);
  assign out_free    = !out_valid || out_ready;
  assign pop         = (state == S_IDLE) && !empty && out_free;
  assign div_start   = pop && (head.kind == fpt_pkg::CMD_GET) && (head.period != '0);
  assign elapsed_inc = (elapsed == fpt_pkg::ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
  assign wd_fire     = (elapsed_inc >= wdog_period);

  always_comb begin
    state_next   = state;
    elapsed_next = elapsed;
    load         = 1'b0;
    res_status   = fpt_pkg::STAT_OK;
    res_rpm      = '0;
    for (int i = 0; i < NUM_FANS; i++) begin
      duty_next[i] = duty[i];
    end
    case (state)
      S_IDLE: begin
        if (pop) begin
          load = 1'b1;
          case (head.kind)
            fpt_pkg::CMD_TICK: begin
              if (wd_fire) begin
                elapsed_next = '0;
                res_status   = fpt_pkg::STAT_WDOG;
                for (int i = 0; i < NUM_FANS; i++) begin
                  duty_next[i] = emerg_duty;
                end
              end else begin
                elapsed_next = elapsed_inc;
              end
            end
            fpt_pkg::CMD_KICK: begin
              elapsed_next = '0;
            end
            fpt_pkg::CMD_SET: begin
              for (int i = 0; i < NUM_FANS; i++) begin
                if (head.fan_number == fpt_pkg::FAN_W'(i + 1)) begin
                  duty_next[i] = head.duty;
                end
              end
            end
            fpt_pkg::CMD_GET: begin
              if (head.period != '0) begin
                load       = 1'b0;
                state_next = S_DIV;
              end
            end
            default: begin
              res_status = fpt_pkg::STAT_BAD_FAN;
            end
          endcase
        end
      end
      S_DIV: begin
        if (!div_busy && out_free) begin
          load       = 1'b1;
          res_rpm    = div_quotient;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  for (genvar j = 0; j < 4; j++) begin : g_shown
    if (j < NUM_FANS) begin : g_fan
      assign shown[j] = duty_next[j];
    end else begin : g_none
      assign shown[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      elapsed   <= '0;
      for (int i = 0; i < NUM_FANS; i++) begin
        duty[i] <= fpt_pkg::DUTY_MAX;
      end
    end else begin
      state   <= state_next;
      elapsed <= elapsed_next;
      for (int i = 0; i < NUM_FANS; i++) begin
        duty[i] <= duty_next[i];
      end
      if (load) begin
        out_valid               <= 1'b1;
        out_word.status         <= res_status;
        out_word.rpm            <= res_rpm;
        out_word.duty_fan_one   <= shown[0];
        out_word.duty_fan_two   <= shown[1];
        out_word.duty_fan_three <= shown[2];
        out_word.duty_fan_four  <= shown[3];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_div_only_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIV)
    else $error("divider running outside a get");

  a_rpm_zero_on_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != fpt_pkg::STAT_OK |-> out_word.rpm == '0)
    else $error("rpm nonzero on a non-ok word");

  a_wdog_restart: assert property (@(posedge clk) disable iff (rst)
    pop && head.kind == fpt_pkg::CMD_TICK && wd_fire
      |=> elapsed == '0 && out_valid && out_word.status == fpt_pkg::STAT_WDOG)
    else $error("watchdog expiry not applied");

endmodule

[tb/sv/fan_pwm_tach_watchdog_controller_test.sv]
`timescale 1ns / 1ps

module fan_pwm_tach_watchdog_controller_test;

  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 188;
  localparam int unsigned RPM_SCALE = 30000000;

  typedef struct {
    logic wr;
    logic [fpt_pkg::CFG_IDX_W-1:0] wr_index;
    logic [fpt_pkg::CFG_DATA_W-1:0] wr_value;
    fpt_pkg::in_word_t cmd;
    logic typed;
    fpt_pkg::out_word_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  fpt_pkg::in_word_t in_word;
  logic out_valid;
  logic out_ready = 1'b0;
  fpt_pkg::out_word_t out_word;
  logic cfg_we;
  logic [fpt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fpt_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [fpt_pkg::WDOG_W-1:0] wd_elapsed;
  logic [fpt_pkg::WDOG_W-1:0] wd_period;
  logic [fpt_pkg::PCT_W-1:0] emerg_pct;
  logic [fpt_pkg::DUTY_W-1:0] fan_duty_now [fpt_pkg::NUM_FANS];

  fpt_pkg::out_word_t fan_reports_due[$];
  step_row_t step_rows[$];

  int error_count = 0;
  int checked_count = 0;
  int random_count = 0;
  int wdog_fired = 0;
  int bad_fans = 0;
  int speed_reads = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int unsigned phase_period [PHASES] = '{4, 0, 1, 9, 1048575, 2, 25, 13};
  int unsigned phase_pct [PHASES] = '{100, 0, 127, 55, 73, 1, 99, 101};

  fan_pwm_tach_watchdog_controller dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [fpt_pkg::DUTY_W-1:0] pct_to_duty(
      input logic [fpt_pkg::PCT_W-1:0] pct);
    int unsigned d;
    d = pct * 255 / 100;
    return (d > 255) ? 8'd255 : 8'(d);
  endfunction

  function automatic fpt_pkg::out_word_t fan_cmd_result(input fpt_pkg::in_word_t w);
    fpt_pkg::out_word_t res;
    int unsigned span;
    logic fan_ok;
    res = '0;
    res.status = fpt_pkg::STAT_OK;
    fan_ok = (w.fan_number >= 1) && (w.fan_number <= fpt_pkg::NUM_FANS);
    case (w.opcode)
      fpt_pkg::OP_TICK: begin
        if (wd_elapsed != fpt_pkg::ELAPSED_MAX) wd_elapsed = wd_elapsed + 1'b1;
        if (wd_elapsed >= wd_period) begin
          for (int i = 0; i < fpt_pkg::NUM_FANS; i++) fan_duty_now[i] = pct_to_duty(emerg_pct);
          wd_elapsed = '0;
          res.status = fpt_pkg::STAT_WDOG;
        end
      end
      fpt_pkg::OP_KICK: wd_elapsed = '0;
      default: begin
        if (!fan_ok) begin
          res.status = fpt_pkg::STAT_BAD_FAN;
        end else if (w.opcode == fpt_pkg::OP_SET) begin
          fan_duty_now[w.fan_number - 1] = pct_to_duty(w.percent);
        end else begin
          span = w.tach_high_us + w.tach_low_us;
          if (span != 0) res.rpm = fpt_pkg::RPM_W'(RPM_SCALE / span);
        end
      end
    endcase
    res.duty_fan_one = fan_duty_now[0];
    res.duty_fan_two = fan_duty_now[1];
    res.duty_fan_three = fan_duty_now[2];
    res.duty_fan_four = fan_duty_now[3];
    return res;
  endfunction

  function automatic fpt_pkg::in_word_t cmd(input fpt_pkg::opcode_t op,
                                            input int unsigned fan,
                                            input int unsigned pct, input int unsigned th,
                                            input int unsigned tl);
    fpt_pkg::in_word_t w;
    w.opcode = op;
    w.fan_number = fpt_pkg::FAN_W'(fan);
    w.percent = fpt_pkg::PCT_W'(pct);
    w.tach_high_us = fpt_pkg::TACH_W'(th);
    w.tach_low_us = fpt_pkg::TACH_W'(tl);
    return w;
  endfunction

  function automatic fpt_pkg::out_word_t readout(input fpt_pkg::status_t st,
                                                 input int unsigned rpm,
                                                 input int unsigned d1, input int unsigned d2,
                                                 input int unsigned d3, input int unsigned d4);
    fpt_pkg::out_word_t r;
    r.status = st;
    r.rpm = fpt_pkg::RPM_W'(rpm);
    r.duty_fan_one = fpt_pkg::DUTY_W'(d1);
    r.duty_fan_two = fpt_pkg::DUTY_W'(d2);
    r.duty_fan_three = fpt_pkg::DUTY_W'(d3);
    r.duty_fan_four = fpt_pkg::DUTY_W'(d4);
    return r;
  endfunction

  function automatic fpt_pkg::in_word_t rand_cmd();
    fpt_pkg::in_word_t w;
    int unsigned r;
    w.fan_number = ($urandom_range(99) < 85) ? fpt_pkg::FAN_W'($urandom_range(4, 1))
                                             : fpt_pkg::FAN_W'($urandom_range(7));
    w.percent = ($urandom_range(3) == 0) ? fpt_pkg::PCT_W'($urandom_range(127, 100))
                                         : fpt_pkg::PCT_W'($urandom_range(127));
    case ($urandom_range(9))
      0: begin
        w.tach_high_us = '0;
        w.tach_low_us = '0;
      end
      1: begin
        w.tach_high_us = '0;
        w.tach_low_us = fpt_pkg::TACH_W'($urandom_range(3));
      end
      2, 3, 4: begin
        w.tach_high_us = fpt_pkg::TACH_W'($urandom_range(4095));
        w.tach_low_us = fpt_pkg::TACH_W'($urandom_range(4095));
      end
      default: begin
        w.tach_high_us = fpt_pkg::TACH_W'($urandom_range(20'hFFFFF));
        w.tach_low_us = fpt_pkg::TACH_W'($urandom_range(20'hFFFFF));
      end
    endcase
    r = $urandom_range(99);
    w.opcode = (r < 35) ? fpt_pkg::OP_TICK : (r < 45) ? fpt_pkg::OP_KICK :
               (r < 72) ? fpt_pkg::OP_SET : fpt_pkg::OP_GET;
    return w;
  endfunction

  task automatic add_row(input logic wr, input logic [fpt_pkg::CFG_IDX_W-1:0] idx,
                         input int unsigned val, input fpt_pkg::in_word_t c,
                         input logic typed, input fpt_pkg::out_word_t want);
    step_row_t row;
    row.wr = wr;
    row.wr_index = idx;
    row.wr_value = fpt_pkg::CFG_DATA_W'(val);
    row.cmd = c;
    row.typed = typed;
    row.want = want;
    step_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic check_word(input fpt_pkg::out_word_t got, input fpt_pkg::out_word_t want);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.rpm !== want.rpm) report_mismatch("rpm", got.rpm, want.rpm);
    if (got.duty_fan_one !== want.duty_fan_one)
      report_mismatch("duty fan 1", got.duty_fan_one, want.duty_fan_one);
    if (got.duty_fan_two !== want.duty_fan_two)
      report_mismatch("duty fan 2", got.duty_fan_two, want.duty_fan_two);
    if (got.duty_fan_three !== want.duty_fan_three)
      report_mismatch("duty fan 3", got.duty_fan_three, want.duty_fan_three);
    if (got.duty_fan_four !== want.duty_fan_four)
      report_mismatch("duty fan 4", got.duty_fan_four, want.duty_fan_four);
  endtask

  task automatic send_cmd(input fpt_pkg::in_word_t w, input logic typed,
                          input fpt_pkg::out_word_t want);
    fpt_pkg::out_word_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = fan_cmd_result(w);
    fan_reports_due.push_back(typed ? want : predicted);
    if (predicted.status == fpt_pkg::STAT_WDOG) wdog_fired++;
    if (predicted.status == fpt_pkg::STAT_BAD_FAN) bad_fans++;
    if (w.opcode == fpt_pkg::OP_GET) speed_reads++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (fan_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fpt_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= fpt_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    if (idx == fpt_pkg::CFG_WDOG_PERIOD) wd_period = fpt_pkg::WDOG_W'(val);
    else emerg_pct = fpt_pkg::PCT_W'(val);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        checked_count++;
        if (fan_reports_due.size() == 0)
          report_mismatch("word with nothing pending, status", out_word.status, 0);
        else
          check_word(out_word, fan_reports_due.pop_front());
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    fpt_pkg::out_word_t none;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wd_period = fpt_pkg::WDOG_PERIOD_INIT;
    emerg_pct = fpt_pkg::EMERG_PCT_INIT;
    wd_elapsed = '0;
    for (int i = 0; i < fpt_pkg::NUM_FANS; i++) fan_duty_now[i] = 8'd255;

    // after reset: all duties at the full 255
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_KICK, 0, 0, 0, 0), 1,
            readout(fpt_pkg::STAT_OK, 0, 255, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_GET, 0, 0, 5, 5), 1,
            readout(fpt_pkg::STAT_BAD_FAN, 0, 255, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_SET, 5, 50, 0, 0), 1,
            readout(fpt_pkg::STAT_BAD_FAN, 0, 255, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0,
            cmd(fpt_pkg::OP_GET, 7, 127, 20'hFFFFF, 20'hFFFFF), 1,
            readout(fpt_pkg::STAT_BAD_FAN, 0, 255, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_GET, 1, 0, 0, 0), 1,
            readout(fpt_pkg::STAT_OK, 0, 255, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_GET, 4, 0, 1, 0), 1,
            readout(fpt_pkg::STAT_OK, 30000000, 255, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0,
            cmd(fpt_pkg::OP_GET, 2, 0, 20'hFFFFF, 20'hFFFFF), 1,
            readout(fpt_pkg::STAT_OK, 14, 255, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_GET, 3, 0, 0, 20'hFFFFF), 1,
            readout(fpt_pkg::STAT_OK, 28, 255, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_SET, 1, 0, 0, 0), 1,
            readout(fpt_pkg::STAT_OK, 0, 0, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_SET, 2, 100, 0, 0), 1,
            readout(fpt_pkg::STAT_OK, 0, 0, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_SET, 3, 127, 0, 0), 1,
            readout(fpt_pkg::STAT_OK, 0, 0, 255, 255, 255));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_SET, 4, 1, 0, 0), 0, none);
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_SET, 1, 99, 0, 0), 0, none);
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_SET, 2, 50, 0, 0), 0, none);
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_TICK, 0, 0, 0, 0), 0, none);
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_GET, 4, 0, 12345, 6789), 0,
            none);
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0,
            cmd(fpt_pkg::OP_TICK, 7, 127, 20'hFFFFF, 20'hFFFFF), 0, none);
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_KICK, 0, 127, 20'hFFFFF, 0), 0,
            none);
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_SET, 1, 101, 0, 0), 0, none);
    // watchdog expiry, then a zero period firing on every tick
    add_row(1, fpt_pkg::CFG_WDOG_PERIOD, 2, cmd(fpt_pkg::OP_TICK, 0, 0, 0, 0), 0, none);
    add_row(1, fpt_pkg::CFG_EMERG_PCT, 30, cmd(fpt_pkg::OP_TICK, 0, 0, 0, 0), 1,
            readout(fpt_pkg::STAT_WDOG, 0, 76, 76, 76, 76));
    add_row(1, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_TICK, 0, 0, 0, 0), 1,
            readout(fpt_pkg::STAT_WDOG, 0, 76, 76, 76, 76));
    add_row(1, fpt_pkg::CFG_EMERG_PCT, 127, cmd(fpt_pkg::OP_TICK, 0, 0, 0, 0), 1,
            readout(fpt_pkg::STAT_WDOG, 0, 255, 255, 255, 255));
    add_row(1, fpt_pkg::CFG_EMERG_PCT, 0, cmd(fpt_pkg::OP_TICK, 0, 0, 0, 0), 1,
            readout(fpt_pkg::STAT_WDOG, 0, 0, 0, 0, 0));
    add_row(0, fpt_pkg::CFG_WDOG_PERIOD, 0, cmd(fpt_pkg::OP_KICK, 3, 64, 0, 0), 0, none);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (step_rows[k]) begin
      if (step_rows[k].wr) begin
        settle();
        write_reg(step_rows[k].wr_index, step_rows[k].wr_value);
        cfg_we <= 1'b0;
      end
      send_cmd(step_rows[k].cmd, step_rows[k].typed, step_rows[k].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(fpt_pkg::CFG_WDOG_PERIOD, phase_period[ph]);
      write_reg(fpt_pkg::CFG_EMERG_PCT, phase_pct[ph]);
      cfg_we <= 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_cmd(rand_cmd(), 1'b0, none);
        random_count++;
      end
    end

    in_valid <= 1'b0;
    while (fan_reports_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("ran %0d table rows and %0d random commands over %0d register settings",
             step_rows.size(), random_count, PHASES);
    $display("checked %0d results: %0d watchdog expiries, %0d bad fan numbers, %0d speed reads",
             checked_count, wdog_fired, bad_fans, speed_reads);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
